>>> sv/sbpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_pkg
// Shared types and codes of the sigma band price outlier filter.
// ----------------------------------------------------------------------------
package sbpf_pkg;

    // Fixed field widths
    localparam int CFG_W    = 12;
    localparam int IDX_W    = 12;
    localparam int REPORT_W = 24;
    localparam int STATUS_W = 2;
    localparam int OPND_W   = 64;
    localparam int BOUND_W  = 26;
    localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};

    // Configuration register indexes
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_END_SPAN  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] TOLERANCE_RST = 12'd768;
    localparam logic [CFG_W-1:0] END_SPAN_RST  = 12'd100;

    // Request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result kinds
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_STATS   = 2'd3;

    // Shared divide / square root unit
    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

>>> sv/sbpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbpf_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/sbpf_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_divsqrt
// Shared radix-2 unit: 64-bit restoring division by a narrow divisor, or
// 64-bit integer square root, one trial subtraction per cycle.
// ----------------------------------------------------------------------------
module sbpf_divsqrt #(
    parameter int DVW = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbpf_pkg::unit_cmd_t          cmd,
    input  logic [sbpf_pkg::OPND_W-1:0]  opnd,
    input  logic [DVW-1:0]               divisor,
    output logic [sbpf_pkg::OPND_W-1:0]  result,
    output sbpf_pkg::unit_stat_t         stat
);
    import sbpf_pkg::*;

    localparam int RW = OPND_W + 2;
    localparam int HW = OPND_W / 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    unit_op_t          op_reg, op_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [OPND_W-1:0] quo_reg, quo_next;
    logic [HW-1:0]     root_reg, root_next;
    logic [DVW-1:0]    div_reg, div_next;

    logic [RW-1:0]     trial_a;
    logic [RW-1:0]     trial_b;
    logic [RW:0]       diff;
    logic              ge;

    // Trial subtraction shared by both operations
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            trial_a = {rem_reg[RW-3:0], quo_reg[OPND_W-1 -: 2]};
            trial_b = RW'({root_reg, 2'b01});
        end
        else
        begin
            trial_a = {rem_reg[RW-2:0], quo_reg[OPND_W-1]};
            trial_b = RW'(div_reg);
        end
        diff = {1'b0, trial_a} - {1'b0, trial_b};
        ge   = ~diff[RW];
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        root_next = root_reg;
        div_next  = div_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = (cmd.op == OP_SQRT) ? 7'(HW - 1) : 7'(OPND_W - 1);
            rem_next  = '0;
            quo_next  = opnd;
            root_next = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[RW-1:0] : trial_a;
            if (op_reg == OP_SQRT)
            begin
                quo_next  = {quo_reg[OPND_W-3:0], 2'b00};
                root_next = {root_reg[HW-2:0], ge};
            end
            else
            begin
                quo_next = {quo_reg[OPND_W-2:0], ge};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        root_reg <= root_next;
        div_reg  <= div_next;
    end

    assign result    = (op_reg == OP_SQRT) ? OPND_W'(root_reg) : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> sv/sigma_band_price_outlier_filter_core.sv
`timescale 1ns / 1ps
// A non-last load gives no result; a query is answered with its verdict from the
//   query state, held back while the output stalls; one request at a time.
// A last load starts the pass: store reads and drain of the sampled ticks, a
//   mean division, a mean-square division and a square root in the shared divide /
//   root unit, then handoff and band math and the report, which output stalls can
//   hold back (an empty sample skips the unit). Reset (rst_n low, async)
//   clears count, band and flags and restores the configuration defaults.
// ----------------------------------------------------------------------------
// sigma_band_price_outlier_filter_core
// Tick store with a sampled mean / deviation pass and band verdict queries.
// ----------------------------------------------------------------------------
module sigma_band_price_outlier_filter_core #(
    parameter int MAX_TICKS  = 4096,
    parameter int PRICE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [sbpf_pkg::CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [PRICE_BITS-1:0]          price,
    input  logic                           is_signal,
    input  logic                           is_last,
    input  logic [sbpf_pkg::IDX_W-1:0]     query_index,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic                           keep,
    output logic [sbpf_pkg::IDX_W-1:0]     item_index,
    output logic [sbpf_pkg::REPORT_W-1:0]  mean_price,
    output logic [sbpf_pkg::REPORT_W-1:0]  spread,
    output logic [sbpf_pkg::STATUS_W-1:0]  status
);
    import sbpf_pkg::*;

    localparam int AW  = $clog2(MAX_TICKS);
    localparam int LW  = AW + 1;
    localparam int CW  = (LW > CFG_W + 1) ? LW : CFG_W + 1;
    localparam int IW  = (LW > IDX_W) ? LW : IDX_W;
    localparam int EW  = PRICE_BITS + 1;
    localparam int PSW = PRICE_BITS + CW;
    localparam int BW  = (PRICE_BITS > BOUND_W) ? PRICE_BITS : BOUND_W;
    localparam int HW  = OPND_W / 2;
    localparam int DLW = CFG_W + HW - 8;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SCAN   = 12'b0000_0000_0010,
        S_DRAIN  = 12'b0000_0000_0100,
        S_MEAN   = 12'b0000_0000_1000,
        S_MSQ    = 12'b0000_0001_0000,
        S_SQUARE = 12'b0000_0010_0000,
        S_VAR    = 12'b0000_0100_0000,
        S_ROOT   = 12'b0000_1000_0000,
        S_DELTA  = 12'b0001_0000_0000,
        S_BAND   = 12'b0010_0000_0000,
        S_OUT    = 12'b0100_0000_0000,
        S_QUERY  = 12'b1000_0000_0000
    } state_t;

    state_t                state_reg, state_next;

    logic [CFG_W-1:0]      tolerance_reg;
    logic [CFG_W-1:0]      end_span_reg;
    logic [LW-1:0]         loaded_count_reg, loaded_count_next;
    logic                  stats_ready_reg, stats_ready_next;
    logic                  overflow_reg, overflow_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         m_reg, m_next;
    logic [PSW-1:0]        price_sum_reg, price_sum_next;
    logic [OPND_W-1:0]     square_sum_reg, square_sum_next;
    logic                  v1_reg, v2_reg;
    logic [PRICE_BITS-1:0] p_d_reg;
    logic                  sig_d_reg;
    logic [2*PRICE_BITS-1:0] sqp_reg;
    logic [PRICE_BITS-1:0] mean_reg, mean_next;
    logic [OPND_W-1:0]     msq_reg, msq_next;
    logic [OPND_W-1:0]     sq_reg, sq_next;
    logic [HW-1:0]         sd_reg, sd_next;
    logic [DLW-1:0]        delta_reg, delta_next;
    logic [BW-1:0]         upper_reg, upper_next;
    logic [BW-1:0]         lower_reg, lower_next;
    logic [IDX_W-1:0]      q_index_reg, q_index_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  result_kind_reg, result_kind_next;
    logic                  keep_reg, keep_next;
    logic [IDX_W-1:0]      item_index_reg, item_index_next;
    logic [REPORT_W-1:0]   mean_price_reg, mean_price_next;
    logic [REPORT_W-1:0]   spread_reg, spread_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  in_acc;
    logic                  load_acc;
    logic                  query_acc;
    logic                  out_free;
    logic [LW-1:0]         base_cnt;
    logic                  store_full;
    logic [CW-1:0]         n_w;
    logic [CW-1:0]         two_s;
    logic                  long_set;
    logic [CW-1:0]         total;
    logic [CW-1:0]         scan_addr;
    logic                  scan_rd;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;
    logic [OPND_W-1:0]     var_c;
    logic [CFG_W+HW-1:0]   tol_prod;
    logic [DLW:0]          up_sum;
    logic [IW-1:0]         qi_w;
    logic                  q_inside;

    unit_cmd_t             ucmd;
    unit_stat_t            ustat;
    logic [OPND_W-1:0]     uopnd;
    logic [OPND_W-1:0]     ures;

    assign in_acc    = in_valid && !in_stall;
    assign load_acc  = in_acc && (func == FUNC_LOAD);
    assign query_acc = in_acc && (func == FUNC_QUERY);
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_free  = !out_valid_reg || !out_stall;

    // Store position of a new tick; a closed set restarts at zero
    assign base_cnt   = stats_ready_reg ? '0 : loaded_count_reg;
    assign store_full = base_cnt >= LW'(MAX_TICKS);

    // Sample walk: whole set, or head and tail of end_span each
    assign n_w       = CW'(loaded_count_reg);
    assign two_s     = CW'({end_span_reg, 1'b0});
    assign long_set  = n_w > two_s;
    assign total     = long_set ? two_s : n_w;
    assign scan_rd   = (state_reg == S_SCAN) && (k_reg < total);
    assign scan_addr = k_reg + ((long_set && (k_reg >= CW'(end_span_reg)))
                                ? (n_w - two_s) : '0);
    assign ram_re    = scan_rd || query_acc;
    assign ram_raddr = (state_reg == S_SCAN) ? scan_addr[AW-1:0] : AW'(query_index);

    sbpf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TICKS)
    ) u_store (
        .clk   (clk),
        .we    (load_acc && !store_full),
        .waddr (base_cnt[AW-1:0]),
        .wdata ({is_signal, price}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Band math helpers
    assign var_c    = (msq_reg > sq_reg) ? (msq_reg - sq_reg) : '0;
    assign tol_prod = (CFG_W+HW)'(tolerance_reg) * (CFG_W+HW)'(sd_reg);
    assign up_sum   = (DLW+1)'(mean_reg) + (DLW+1)'(delta_reg);

    // Query check against the band
    assign qi_w     = IW'(q_index_reg);
    assign q_inside = ram_rdata[PRICE_BITS]
                      && (BW'(ram_rdata[PRICE_BITS-1:0]) >= lower_reg)
                      && (BW'(ram_rdata[PRICE_BITS-1:0]) <= upper_reg);

    // Shared divide / root unit
    always_comb
    begin
        ucmd.start = 1'b0;
        ucmd.op    = OP_DIV;
        uopnd      = OPND_W'(price_sum_reg);
        unique case (state_reg)
            S_DRAIN:
            begin
                ucmd.start = !v1_reg && !v2_reg && (m_reg != '0);
            end
            S_MEAN:
            begin
                ucmd.start = ustat.done;
                uopnd      = square_sum_reg;
            end
            S_VAR:
            begin
                ucmd.start = 1'b1;
                ucmd.op    = OP_SQRT;
                uopnd      = var_c;
            end
            default:
            begin
                ucmd.start = 1'b0;
            end
        endcase
    end

    sbpf_divsqrt #(
        .DVW (CW)
    ) u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ucmd),
        .opnd    (uopnd),
        .divisor (m_reg),
        .result  (ures),
        .stat    (ustat)
    );

    // Sequencer and next state
    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        stats_ready_next  = stats_ready_reg;
        overflow_next     = overflow_reg;
        k_next            = k_reg;
        m_next            = m_reg;
        price_sum_next    = price_sum_reg;
        square_sum_next   = square_sum_reg;
        mean_next         = mean_reg;
        msq_next          = msq_reg;
        sq_next           = sq_reg;
        sd_next           = sd_reg;
        delta_next        = delta_reg;
        upper_next        = upper_reg;
        lower_next        = lower_reg;
        q_index_next      = q_index_reg;
        out_valid_next    = out_valid_reg && out_stall;
        result_kind_next  = result_kind_reg;
        keep_next         = keep_reg;
        item_index_next   = item_index_reg;
        mean_price_next   = mean_price_reg;
        spread_next       = spread_reg;
        status_next       = status_reg;

        // accumulate sampled signal ticks
        if (v2_reg && sig_d_reg)
        begin
            price_sum_next  = price_sum_reg + PSW'(p_d_reg);
            square_sum_next = square_sum_reg + OPND_W'(sqp_reg);
            m_next          = m_reg + CW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    stats_ready_next = 1'b0;
                    if (store_full)
                    begin
                        loaded_count_next = base_cnt;
                        overflow_next     = 1'b1;
                    end
                    else
                    begin
                        loaded_count_next = base_cnt + LW'(1);
                        overflow_next     = stats_ready_reg ? 1'b0 : overflow_reg;
                    end
                    if (is_last)
                    begin
                        k_next          = '0;
                        m_next          = '0;
                        price_sum_next  = '0;
                        square_sum_next = '0;
                        state_next      = S_SCAN;
                    end
                end
                else if (query_acc)
                begin
                    q_index_next = query_index;
                    state_next   = S_QUERY;
                end
            end
            S_SCAN:
            begin
                if (scan_rd)
                begin
                    k_next = k_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    if (m_reg == '0)
                    begin
                        mean_next  = '0;
                        sd_next    = '0;
                        upper_next = BW'(BOUND_MAX);
                        lower_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MEAN;
                    end
                end
            end
            S_MEAN:
            begin
                if (ustat.done)
                begin
                    mean_next  = ures[PRICE_BITS-1:0];
                    state_next = S_MSQ;
                end
            end
            S_MSQ:
            begin
                if (ustat.done)
                begin
                    msq_next   = ures;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                sq_next    = OPND_W'((2*PRICE_BITS)'(mean_reg) * (2*PRICE_BITS)'(mean_reg));
                state_next = S_VAR;
            end
            S_VAR:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (ustat.done)
                begin
                    sd_next    = ures[HW-1:0];
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                delta_next = tol_prod[CFG_W+HW-1:8];
                state_next = S_BAND;
            end
            S_BAND:
            begin
                upper_next = (up_sum > (DLW+1)'(BOUND_MAX)) ? BW'(BOUND_MAX)
                                                            : BW'(up_sum);
                lower_next = (DLW'(mean_reg) > delta_reg)
                             ? BW'(DLW'(mean_reg) - delta_reg) : '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    result_kind_next = KIND_REPORT;
                    keep_next        = 1'b0;
                    item_index_next  = '0;
                    mean_price_next  = REPORT_W'(mean_reg);
                    spread_next      = REPORT_W'(sd_reg);
                    status_next      = overflow_reg ? ST_OVERFLOW : ST_OK;
                    stats_ready_next = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_QUERY:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    result_kind_next = KIND_VERDICT;
                    item_index_next  = q_index_reg;
                    mean_price_next  = '0;
                    spread_next      = '0;
                    keep_next        = 1'b0;
                    if (!stats_ready_reg)
                    begin
                        status_next = ST_NO_STATS;
                    end
                    else if ((qi_w >= IW'(loaded_count_reg))
                             || (32'(q_index_reg) >= 32'(MAX_TICKS)))
                    begin
                        status_next = ST_NOT_LOADED;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        keep_next   = q_inside;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tolerance_reg    <= TOLERANCE_RST;
            end_span_reg     <= END_SPAN_RST;
            loaded_count_reg <= '0;
            stats_ready_reg  <= 1'b0;
            overflow_reg     <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            upper_reg        <= '0;
            lower_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            stats_ready_reg  <= stats_ready_next;
            overflow_reg     <= overflow_next;
            v1_reg           <= scan_rd;
            v2_reg           <= v1_reg;
            upper_reg        <= upper_next;
            lower_reg        <= lower_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TOLERANCE: tolerance_reg <= cfg_data;
                    REG_END_SPAN:  end_span_reg  <= cfg_data;
                    default:       tolerance_reg <= tolerance_reg;
                endcase
            end
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        m_reg           <= m_next;
        price_sum_reg   <= price_sum_next;
        square_sum_reg  <= square_sum_next;
        p_d_reg         <= ram_rdata[PRICE_BITS-1:0];
        sig_d_reg       <= ram_rdata[PRICE_BITS];
        sqp_reg         <= ram_rdata[PRICE_BITS-1:0] * ram_rdata[PRICE_BITS-1:0];
        mean_reg        <= mean_next;
        msq_reg         <= msq_next;
        sq_reg          <= sq_next;
        sd_reg          <= sd_next;
        delta_reg       <= delta_next;
        q_index_reg     <= q_index_next;
        result_kind_reg <= result_kind_next;
        keep_reg        <= keep_next;
        item_index_reg  <= item_index_next;
        mean_price_reg  <= mean_price_next;
        spread_reg      <= spread_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign keep        = keep_reg;
    assign item_index  = item_index_reg;
    assign mean_price  = mean_price_reg;
    assign spread      = spread_reg;
    assign status      = status_reg;

    // An accepted query is answered from the query state
    a_query_path: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> (state_reg == S_QUERY))
        else $error("query did not enter the answer state");

    // The shared unit only finishes while the sequencer waits for it
    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        ustat.done |-> (state_reg == S_MEAN || state_reg == S_MSQ
                        || state_reg == S_ROOT))
        else $error("divide / root result arrived in an unexpected state");

    // The unit is never restarted while busy
    a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        ucmd.start |-> !ustat.busy)
        else $error("shared unit started while busy");

    // A report closes the set
    a_report_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (stats_ready_reg && out_valid_reg))
        else $error("report issued without closing the set");

    // The stored count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= LW'(MAX_TICKS))
        else $error("loaded count exceeds store depth");

endmodule

>>> test/tb_sigma_band_price_outlier_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sigma_band_price_outlier_filter_core
// Loads tick sets of random length and content into the filter core, queries
// verdicts of stored ticks, and compares every report and verdict against a
// cycle-free prediction of the sample statistics and the sigma band.
// ----------------------------------------------------------------------------
module tb_sigma_band_price_outlier_filter_core;
    import sbpf_pkg::*;

    localparam int MAX_TICKS  = 4096;
    localparam int PRICE_BITS = 24;
    localparam int WATCH_LIMIT = 40000;

    typedef struct {
        logic                  func;
        logic [PRICE_BITS-1:0] price;
        logic                  is_signal;
        logic                  is_last;
        logic [IDX_W-1:0]      query_index;
    } request_t;

    typedef struct {
        logic                  result_kind;
        logic                  keep;
        logic [IDX_W-1:0]      item_index;
        logic [REPORT_W-1:0]   mean_price;
        logic [REPORT_W-1:0]   spread;
        logic [STATUS_W-1:0]   status;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [PRICE_BITS-1:0] price;
    logic is_signal;
    logic is_last;
    logic [IDX_W-1:0] query_index;
    logic out_valid;
    logic out_stall;
    logic result_kind;
    logic keep;
    logic [IDX_W-1:0] item_index;
    logic [REPORT_W-1:0] mean_price;
    logic [REPORT_W-1:0] spread;
    logic [STATUS_W-1:0] status;

    sigma_band_price_outlier_filter_core #(
        .MAX_TICKS(MAX_TICKS),
        .PRICE_BITS(PRICE_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .price(price), .is_signal(is_signal), .is_last(is_last),
        .query_index(query_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .keep(keep), .item_index(item_index),
        .mean_price(mean_price), .spread(spread), .status(status)
    );

    // Predictor state
    logic [PRICE_BITS:0]   tick_mem [MAX_TICKS];
    int unsigned           tick_count;
    logic [BOUND_W-1:0]    band_hi;
    logic [BOUND_W-1:0]    band_lo;
    bit                    band_valid;
    bit                    store_full_hit;
    logic [CFG_W-1:0]      tol_reg;
    logic [CFG_W-1:0]      sample_reg;

    request_t pending_requests [$];
    verdict_t expected_results [$];
    int  mismatch_count;
    int  reports_seen;
    int  verdicts_seen;
    int  loads_sent;
    bit  quiet_phase;
    bit  sender_hold;
    bit  in_taken;
    int  in_gap;
    int  out_gap;
    int  idle_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Fold one stored tick into the sample sums
    task automatic add_to_sample(input int unsigned pos, inout longint unsigned psum,
                                 inout longint unsigned qsum, inout int unsigned cnt);
        longint unsigned p;
        p = tick_mem[pos][PRICE_BITS-1:0];
        if (tick_mem[pos][PRICE_BITS])
        begin
            psum += p;
            qsum += p * p;
            cnt++;
        end
    endtask

    // Predict the result (if any) of one accepted request
    task automatic predict_filter(input request_t r);
        verdict_t v;
        longint unsigned psum, qsum, mean, msq, sq, var_v, sd, delta, up;
        int unsigned cnt, i;
        v = '{default: '0};
        if (r.func == FUNC_LOAD)
        begin
            if (band_valid)
            begin
                tick_count = 0;
                store_full_hit = 0;
                band_valid = 0;
            end
            if (tick_count < MAX_TICKS)
            begin
                tick_mem[tick_count] = {r.is_signal, r.price};
                tick_count++;
            end
            else
                store_full_hit = 1;
            if (!r.is_last)
                return;
            psum = 0;
            qsum = 0;
            cnt = 0;
            if (tick_count <= 2 * sample_reg)
            begin
                for (i = 0; i < tick_count; i++)
                    add_to_sample(i, psum, qsum, cnt);
            end
            else
            begin
                for (i = 0; i < sample_reg; i++)
                    add_to_sample(i, psum, qsum, cnt);
                for (i = tick_count - sample_reg; i < tick_count; i++)
                    add_to_sample(i, psum, qsum, cnt);
            end
            if (cnt == 0)
            begin
                mean = 0;
                sd = 0;
                band_hi = BOUND_MAX;
                band_lo = '0;
            end
            else
            begin
                mean = psum / cnt;
                msq = qsum / cnt;
                sq = mean * mean;
                var_v = (msq > sq) ? msq - sq : 0;
                sd = int_sqrt(var_v);
                delta = (longint'(tol_reg) * sd) >> 8;
                up = mean + delta;
                band_hi = (up > BOUND_MAX) ? BOUND_MAX : up[BOUND_W-1:0];
                band_lo = (mean > delta) ? BOUND_W'(mean - delta) : '0;
            end
            band_valid = 1;
            v.result_kind = KIND_REPORT;
            v.mean_price = mean[REPORT_W-1:0];
            v.spread = sd[REPORT_W-1:0];
            v.status = store_full_hit ? ST_OVERFLOW : ST_OK;
        end
        else
        begin
            v.result_kind = KIND_VERDICT;
            v.item_index = r.query_index;
            if (!band_valid)
                v.status = ST_NO_STATS;
            else if (r.query_index >= tick_count)
                v.status = ST_NOT_LOADED;
            else
            begin
                v.keep = tick_mem[r.query_index][PRICE_BITS]
                    && tick_mem[r.query_index][PRICE_BITS-1:0] >= band_lo
                    && tick_mem[r.query_index][PRICE_BITS-1:0] <= band_hi;
                v.status = ST_OK;
            end
        end
        expected_results.push_back(v);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Driver: present requests at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_gap > 0)
                in_gap <= in_gap - 1;
            else if (!quiet_phase && $urandom_range(0, 19) == 0)
                in_gap <= $urandom_range(1, 18);
            if (in_valid && !in_taken)
                ;  // hold stalled request
            else if (pending_requests.size() > 0 && in_gap == 0 && !sender_hold)
            begin
                in_valid <= 1'b1;
                func <= pending_requests[0].func;
                price <= pending_requests[0].price;
                is_signal <= pending_requests[0].is_signal;
                is_last <= pending_requests[0].is_last;
                query_index <= pending_requests[0].query_index;
            end
            else
                in_valid <= 1'b0;
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 24) == 0)
            begin
                out_gap <= $urandom_range(1, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: take accepted requests, check results and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_filter(pending_requests.pop_front());
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (pending_requests.size() > 0 || expected_results.size() > 0)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCH_LIMIT)
            begin
                $display("sigma_band_price_outlier_filter_core test failed");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", result_kind, 0);
                else
                begin
                    verdict_t e;
                    e = expected_results.pop_front();
                    if (result_kind !== e.result_kind)
                        report_mismatch("result_kind", result_kind, e.result_kind);
                    if (keep !== e.keep)
                        report_mismatch("keep", keep, e.keep);
                    if (item_index !== e.item_index)
                        report_mismatch("item_index", item_index, e.item_index);
                    if (mean_price !== e.mean_price)
                        report_mismatch("mean_price", mean_price, e.mean_price);
                    if (spread !== e.spread)
                        report_mismatch("spread", spread, e.spread);
                    if (status !== e.status)
                        report_mismatch("status", status, e.status);
                    if (e.result_kind == KIND_REPORT)
                        reports_seen++;
                    else
                        verdicts_seen++;
                end
            end
        end
    end

    function automatic request_t make_load(input logic [PRICE_BITS-1:0] p, input logic s,
                                           input logic l);
        request_t r;
        r = '{func: FUNC_LOAD, price: p, is_signal: s, is_last: l,
              query_index: IDX_W'($urandom)};
        return r;
    endfunction

    function automatic request_t make_query(input logic [IDX_W-1:0] q);
        request_t r;
        r = '{func: FUNC_QUERY, price: PRICE_BITS'($urandom), is_signal: 1'($urandom),
              is_last: 1'($urandom), query_index: q};
        return r;
    endfunction

    task automatic wait_drained();
        wait (pending_requests.size() == 0 && expected_results.size() == 0 && !in_valid);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TOLERANCE)
            tol_reg = val;
        else
            sample_reg = val;
    endtask

    // Queue one tick set, then queries about it
    task automatic queue_set(input int len, input int nq, input int mode);
        int k;
        logic [PRICE_BITS-1:0] base;
        base = PRICE_BITS'($urandom);
        for (k = 0; k < len; k++)
        begin
            logic [PRICE_BITS-1:0] p;
            unique case (mode)
                0: p = PRICE_BITS'($urandom);
                1: p = base + PRICE_BITS'($urandom_range(0, 4095));
                default: p = ($urandom_range(0, 9) == 0) ? PRICE_BITS'($urandom)
                                                          : base ^ PRICE_BITS'($urandom_range(0, 255));
            endcase
            pending_requests.push_back(make_load(p, $urandom_range(0, 5) != 0, k == len - 1));
            loads_sent++;
        end
        for (k = 0; k < nq; k++)
            pending_requests.push_back(make_query($urandom_range(0, 3) == 0 ?
                IDX_W'($urandom) : IDX_W'($urandom_range(0, len))));
    endtask

    initial
    begin
        int ph, total;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TOLERANCE;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_LOAD;
        price = '0;
        is_signal = 1'b0;
        is_last = 1'b0;
        query_index = '0;
        out_stall = 1'b0;
        in_gap = 0;
        out_gap = 0;
        idle_cycles = 0;
        quiet_phase = 0;
        sender_hold = 0;
        in_taken = 0;
        mismatch_count = 0;
        reports_seen = 0;
        verdicts_seen = 0;
        loads_sent = 0;
        tick_count = 0;
        band_hi = '0;
        band_lo = '0;
        band_valid = 0;
        store_full_hit = 0;
        tol_reg = TOLERANCE_RST;
        sample_reg = END_SPAN_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: query before stats, extremes, empty sample, out-of-range query
        pending_requests.push_back(make_query(12'd0));
        pending_requests.push_back(make_load('0, 1'b1, 1'b0));
        pending_requests.push_back(make_load({PRICE_BITS{1'b1}}, 1'b1, 1'b0));
        pending_requests.push_back(make_load(24'h800000, 1'b0, 1'b1));
        pending_requests.push_back(make_query(12'd0));
        pending_requests.push_back(make_query(12'd1));
        pending_requests.push_back(make_query(12'd2));
        pending_requests.push_back(make_query(12'd3));
        pending_requests.push_back(make_query(12'hFFF));
        pending_requests.push_back(make_load(24'h123456, 1'b0, 1'b0));
        pending_requests.push_back(make_load(24'h654321, 1'b0, 1'b1));
        pending_requests.push_back(make_query(12'd0));
        pending_requests.push_back(make_query(12'd1));
        pending_requests.push_back(make_load(24'h001000, 1'b1, 1'b1));
        pending_requests.push_back(make_query(12'd0));
        wait_drained();

        // Register extremes, including a long set sampled at both ends
        write_reg(REG_TOLERANCE, 12'd0);
        write_reg(REG_END_SPAN, 12'd1);
        queue_set(7, 8, 1);
        wait_drained();
        write_reg(REG_TOLERANCE, 12'hFFF);
        write_reg(REG_END_SPAN, 12'hFFF);
        queue_set(9, 10, 2);
        wait_drained();
        pending_requests.push_back(make_query(12'hFFF));
        wait_drained();

        // Random phases with varied settings
        total = 0;
        ph = 0;
        while (total < 1700)
        begin
            int len, nq;
            write_reg(REG_TOLERANCE, ph % 5 == 0 ? 12'd0 : CFG_W'($urandom));
            write_reg(REG_END_SPAN, ph % 4 == 0 ? 12'd2048 : CFG_W'($urandom_range(1, 12)));
            repeat (4)
            begin
                len = $urandom_range(1, 40);
                nq = $urandom_range(0, 12);
                queue_set(len, nq, $urandom_range(0, 2));
                total += len + nq;
            end
            if (ph == 3)
            begin
                sender_hold = 1;
                wait (expected_results.size() == 0 && !in_valid);
                sender_hold = 0;
            end
            if (total > 1450)
                quiet_phase = 1;
            wait_drained();
            ph++;
        end

        wait_drained();
        $display("Covered %0d loads, %0d reports and %0d verdicts over %0d setting phases.",
                 loads_sent, reports_seen, verdicts_seen, ph + 3);
        if (mismatch_count == 0)
            $display("sigma_band_price_outlier_filter_core test passed");
        else
            $display("sigma_band_price_outlier_filter_core test failed");
        $finish;
    end
endmodule
